// ----- design/hsv_pkg.sv -----
package hsv_pkg;

  localparam int HueFracBits = 6;
  localparam int HueW        = 15;
  localparam int LevelW      = 16;
  localparam int PixelW      = 24;
  localparam int ByteW       = 8;

  localparam int SectorSpan  = 60 << HueFracBits;
  localparam int FullCircle  = 6 * SectorSpan;
  localparam int WeightW     = $clog2(SectorSpan + 1);
  localparam int DiffW       = LevelW + WeightW;
  localparam int NumW        = LevelW + DiffW;

  // The divisor 65535 * SectorSpan splits into 2^(HueFracBits+2), 65535 and 15.
  localparam int DivShift    = HueFracBits + 2;
  localparam int N1W         = 36;
  localparam int MidW        = 20;
  localparam int Recip15W    = 21;
  localparam int Recip257W   = 17;
  localparam int RecipShift  = 24;
  localparam logic [Recip15W-1:0]  Recip15  = Recip15W'(1118482);
  localparam logic [Recip257W-1:0] Recip257 = Recip257W'(65281);

  localparam int NumStages   = 7;
  localparam int CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CfgSaturation = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBrightness = 1'b1;

  typedef struct packed {
    logic hue_ld;
    logic weight_ld;
  } sector_ld_t;

  typedef struct packed {
    logic diff_ld;
    logic num_ld;
    logic mid_ld;
    logic level_ld;
    logic out_ld;
  } channel_ld_t;

endpackage

// ----- design/hsv_sector.sv -----
module hsv_sector (
  input  logic                        clk_i,
  input  hsv_pkg::sector_ld_t         ld_i,
  input  logic [hsv_pkg::HueW-1:0]    hue_i,
  output logic [hsv_pkg::WeightW-1:0] u_red_o,
  output logic [hsv_pkg::WeightW-1:0] u_green_o,
  output logic [hsv_pkg::WeightW-1:0] u_blue_o
);
  import hsv_pkg::*;

  localparam logic [2:0] SecRedYellow     = 3'd0;
  localparam logic [2:0] SecYellowGreen   = 3'd1;
  localparam logic [2:0] SecGreenCyan     = 3'd2;
  localparam logic [2:0] SecCyanBlue      = 3'd3;
  localparam logic [2:0] SecBlueMagenta   = 3'd4;
  localparam logic [2:0] SecMagentaRed    = 3'd5;
  localparam logic [WeightW-1:0] SpanW    = WeightW'(SectorSpan);

  logic [HueW-1:0]    hr_d, hr_q;
  logic [2:0]         sector;
  logic [HueW-1:0]    base;
  logic [WeightW-1:0] f, wx, ux;
  logic [WeightW-1:0] u_red_d, u_green_d, u_blue_d;
  logic [WeightW-1:0] u_red_q, u_green_q, u_blue_q;

  assign hr_d = (32'(hue_i) >= FullCircle) ? HueW'(32'(hue_i) - FullCircle) : hue_i;

  always_comb begin
    sector = SecRedYellow;
    for (int k = 1; k < 6; k++) begin
      if (32'(hr_q) >= k * SectorSpan) begin
        sector = 3'(k);
      end
    end
    base = HueW'(32'(sector) * SectorSpan);
    f    = WeightW'(hr_q - base);
    wx   = sector[0] ? SpanW - f : f;
    ux   = SpanW - wx;
  end

  always_comb begin
    case (sector) inside
      SecRedYellow, SecMagentaRed:    u_red_d = '0;
      SecYellowGreen, SecBlueMagenta: u_red_d = ux;
      default:                        u_red_d = SpanW;
    endcase
    case (sector) inside
      SecYellowGreen, SecGreenCyan:   u_green_d = '0;
      SecRedYellow, SecCyanBlue:      u_green_d = ux;
      default:                        u_green_d = SpanW;
    endcase
    case (sector) inside
      SecCyanBlue, SecBlueMagenta:    u_blue_d = '0;
      SecGreenCyan, SecMagentaRed:    u_blue_d = ux;
      default:                        u_blue_d = SpanW;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.hue_ld) begin
      hr_q <= hr_d;
    end
    if (ld_i.weight_ld) begin
      u_red_q   <= u_red_d;
      u_green_q <= u_green_d;
      u_blue_q  <= u_blue_d;
    end
  end

  assign u_red_o   = u_red_q;
  assign u_green_o = u_green_q;
  assign u_blue_o  = u_blue_q;

endmodule

// ----- design/hsv_channel.sv -----
module hsv_channel (
  input  logic                        clk_i,
  input  hsv_pkg::channel_ld_t        ld_i,
  input  logic [hsv_pkg::WeightW-1:0] u_i,
  input  logic [hsv_pkg::LevelW-1:0]  saturation_i,
  input  logic [hsv_pkg::LevelW-1:0]  brightness_i,
  output logic [hsv_pkg::LevelW-1:0]  level_o,
  output logic [hsv_pkg::ByteW-1:0]   byte_o
);
  import hsv_pkg::*;

  localparam logic [DiffW-1:0]  FullScale = DiffW'(65535 * SectorSpan);
  localparam logic [LevelW-1:0] UnitMax   = '1;

  logic [DiffW-1:0]              prod_su;
  logic [DiffW-1:0]              diff_d, diff_q;
  logic [NumW-1:0]               num;
  logic [N1W-1:0]                n1_d, n1_q;
  logic [MidW-1:0]               q0;
  logic [MidW:0]                 r0;
  logic [4:0]                    q1;
  logic [LevelW:0]               r1;
  logic [MidW:0]                 mid_sum;
  logic [MidW-1:0]               mid_d, mid_q;
  logic [MidW+Recip15W-1:0]      prod15;
  logic [LevelW-1:0]             level_d, level_q;
  logic [LevelW+Recip257W-1:0]   prod257;
  logic [LevelW-1:0]             out_level_q;
  logic [ByteW-1:0]              out_byte_q;

  assign prod_su = DiffW'(saturation_i) * DiffW'(u_i);
  assign diff_d  = FullScale - prod_su;

  assign num  = NumW'(brightness_i) * NumW'(diff_q);
  assign n1_d = N1W'(num >> DivShift);

  always_comb begin
    q0      = n1_q[N1W-1:LevelW];
    r0      = (MidW+1)'(n1_q[LevelW-1:0]) + (MidW+1)'(q0);
    q1      = r0[LevelW +: 5];
    r1      = (LevelW+1)'(r0[LevelW-1:0]) + (LevelW+1)'(q1);
    mid_sum = (MidW+1)'(q0) + (MidW+1)'(q1)
            + (MidW+1)'(r1 >= (LevelW+1)'(UnitMax));
    mid_d   = mid_sum[MidW-1:0];
  end

  assign prod15  = (MidW+Recip15W)'(mid_q) * (MidW+Recip15W)'(Recip15);
  assign level_d = prod15[RecipShift +: LevelW];

  assign prod257 = (LevelW+Recip257W)'(level_q) * (LevelW+Recip257W)'(Recip257);

  always_ff @(posedge clk_i) begin
    if (ld_i.diff_ld) begin
      diff_q <= diff_d;
    end
    if (ld_i.num_ld) begin
      n1_q <= n1_d;
    end
    if (ld_i.mid_ld) begin
      mid_q <= mid_d;
    end
    if (ld_i.level_ld) begin
      level_q <= level_d;
    end
    if (ld_i.out_ld) begin
      out_level_q <= level_q;
      out_byte_q  <= prod257[RecipShift +: ByteW];
    end
  end

  assign level_o = out_level_q;
  assign byte_o  = out_byte_q;

endmodule

// ----- design/hsv_to_rgb_converter.sv -----
// HSV to RGB converter for a stream of hues.
// Input channel: in_valid_i / in_ready_o with hue_angle_i in 1/64 degree units;
// hues of 360 degrees or more wrap around the color circle.
// Output channel: out_valid_o / out_ready_i with 16-bit red, green and blue
// levels and a packed 0xRRGGBB pixel with 8 bits per component.
// Saturation and brightness are set through the configuration channel
// (index 0 saturation, index 1 brightness, 65535 meaning 1.0); the channel is
// always ready and should only be written while no item is in flight.
// Throughput is one item per cycle while the receiver is ready: the datapath
// is a seven-stage pipeline whose longest stages hold one 16x28 multiply or a
// constant reciprocal multiply per color.
// Reset clears all stage valid bits and sets saturation and brightness to
// 65535. When the receiver stalls, each stage holds its item and a stage
// still loads whenever the stage after it is empty or moving, so bubbles are
// squeezed out and the input stays ready until the pipeline is full.
module hsv_to_rgb_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hsv_pkg::HueW-1:0]    hue_angle_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hsv_pkg::LevelW-1:0]  red_level_o,
  output logic [hsv_pkg::LevelW-1:0]  green_level_o,
  output logic [hsv_pkg::LevelW-1:0]  blue_level_o,
  output logic [hsv_pkg::PixelW-1:0]  packed_pixel_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hsv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hsv_pkg::LevelW-1:0]  cfg_data_i
);
  import hsv_pkg::*;

  logic [LevelW-1:0]    saturation_q, brightness_q;
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   stage_ready;
  sector_ld_t           sector_ld;
  channel_ld_t          channel_ld;
  logic [WeightW-1:0]   u_red, u_green, u_blue;
  logic [ByteW-1:0]     red_byte, green_byte, blue_byte;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saturation_q <= '1;
      brightness_q <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgSaturation) begin
        saturation_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgBrightness) begin
        brightness_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    stage_ready[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (stage_ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign sector_ld.hue_ld     = stage_ready[0];
  assign sector_ld.weight_ld  = stage_ready[1];
  assign channel_ld.diff_ld   = stage_ready[2];
  assign channel_ld.num_ld    = stage_ready[3];
  assign channel_ld.mid_ld    = stage_ready[4];
  assign channel_ld.level_ld  = stage_ready[5];
  assign channel_ld.out_ld    = stage_ready[6];

  hsv_sector u_sector (
    .clk_i     (clk_i),
    .ld_i      (sector_ld),
    .hue_i     (hue_angle_i),
    .u_red_o   (u_red),
    .u_green_o (u_green),
    .u_blue_o  (u_blue)
  );

  hsv_channel u_red_ch (
    .clk_i        (clk_i),
    .ld_i         (channel_ld),
    .u_i          (u_red),
    .saturation_i (saturation_q),
    .brightness_i (brightness_q),
    .level_o      (red_level_o),
    .byte_o       (red_byte)
  );

  hsv_channel u_green_ch (
    .clk_i        (clk_i),
    .ld_i         (channel_ld),
    .u_i          (u_green),
    .saturation_i (saturation_q),
    .brightness_i (brightness_q),
    .level_o      (green_level_o),
    .byte_o       (green_byte)
  );

  hsv_channel u_blue_ch (
    .clk_i        (clk_i),
    .ld_i         (channel_ld),
    .u_i          (u_blue),
    .saturation_i (saturation_q),
    .brightness_i (brightness_q),
    .level_o      (blue_level_o),
    .byte_o       (blue_byte)
  );

  assign in_ready_o     = stage_ready[0];
  assign out_valid_o    = valid_q[NumStages-1];
  assign packed_pixel_o = {red_byte, green_byte, blue_byte};

endmodule
